### rtl/bthalloc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the boundary-tag heap allocator.
// No dependencies.
package bthalloc_pkg;

	// Heap geometry
	localparam int HEAP_BYTES = 65536;
	localparam int OFF_W      = $clog2(HEAP_BYTES) + 2;  // byte offsets, room past the end
	localparam int IDX_W      = $clog2(HEAP_BYTES) - 2;  // word index into the heap memory
	localparam int HEAP_WORDS = HEAP_BYTES / 4;

	localparam logic [OFF_W-1:0] HEAP_END  = OFF_W'(HEAP_BYTES);
	localparam logic [OFF_W-1:0] MIN_BLOCK = OFF_W'(16);

	// Chunk register limits
	localparam logic [16:0] CHUNK_RESET = 17'd4096;
	localparam logic [16:0] CHUNK_MIN   = 17'd8;
	localparam logic [16:0] CHUNK_MAX   = 17'd65536;

	// Opcodes
	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_ALLOC = 2'd1;
	localparam logic [1:0] OP_FREE  = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO     = 2'd1;
	localparam logic [1:0] ST_NO_MEM   = 2'd2;
	localparam logic [1:0] ST_NOT_INIT = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [16:0] request_size;
		logic [15:0] block_address;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] payload_address;
		logic [16:0] granted_bytes;
	} out_item_t;

	// Size field of a boundary tag, allocated flag dropped
	function automatic logic [OFF_W-1:0] tag_size(input logic [31:0] tag);
		tag_size = {tag[OFF_W-1:3], 3'b000};
	endfunction

	// Tag word from size and allocated flag
	function automatic logic [31:0] make_tag(input logic [OFF_W-1:0] size, input logic used);
		make_tag = {{(32-OFF_W){1'b0}}, size[OFF_W-1:1], used};
	endfunction

	// Growth size: bytes rounded to the nearest multiple of 8 (an even word count), halves up
	function automatic logic [OFF_W-1:0] grow_size(input logic [OFF_W-1:0] bytes);
		grow_size = {bytes[OFF_W-1:3], 3'b000} + (bytes[2] ? OFF_W'(8) : OFF_W'(0));
	endfunction

endpackage

### rtl/boundary_tag_heap_allocator.sv
`timescale 1ns / 1ps
// Boundary-tag heap allocator: sequencer plus heap tag memory.
// Depends on bthalloc_pkg.

// One command item in, one result item out. The heap lives in a single-port
// synchronous RAM of 32-bit tag words (one read or one write per cycle, read
// data available in the next cycle), and every command is a walk of
// read-modify-write steps on it, so one command is in flight at a time; a
// finished result sits in the output register and the next command is taken
// while it waits. Initialize writes the start tags, grows the heap by the
// first chunk and coalesces it; allocate walks block headers in a next-fit
// search from the rover, wrapping once to the heap start, grows the break when
// no free block fits, then carves the block; free walks from the heap start to
// the target block, then updates its tags and coalesces it with free
// neighbours. Rejected commands go straight to the result. The walk over block
// headers through the single RAM port sets the rate, so it depends on the heap
// contents.
// The RAM needs no clearing: only tags written since initialize are read.
// The chunk register (chunk_q) is clamped to 8..65536 when written.
module boundary_tag_heap_allocator (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  bthalloc_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output bthalloc_pkg::out_item_t out_item,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [16:0]             cfg_data
);
	import bthalloc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT_W, S_GROW, S_GROW_W,
		S_MRG_RP, S_MRG_RN, S_MRG_EV, S_MRG_W, S_MRG_END,
		S_CARVE, S_CARVE_W,
		S_SC_H, S_SC_HD, S_SC_RN, S_SC_EV,
		S_FR_H, S_FR_HD, S_FR_R, S_FR_EV, S_FREE_W,
		S_DONE
	} state_t;

	state_t state_q;

	// Heap memory
	logic [31:0]      heap_mem [HEAP_WORDS];
	logic [31:0]      mem_q;
	logic             oor_s1;
	logic [OFF_W-1:0] mem_off;
	logic             mem_we;
	logic [31:0]      mem_wdata;
	logic [31:0]      rd;

	// Allocator state
	logic [OFF_W-1:0] break_q;
	logic [OFF_W-1:0] rover_q;
	logic             ready_q;
	logic [16:0]      chunk_q;

	// Command context
	logic [1:0]       op_q;
	logic [15:0]      addr_q;
	logic [OFF_W-1:0] asize_q;
	logic [OFF_W-1:0] bp_q;
	logic [OFF_W-1:0] size_q;
	logic [OFF_W-1:0] grow_bytes_q;
	logic [31:0]      ptag_q;
	logic [1:0]       cnt_q;
	logic             loop2_q;
	logic             split_q;
	out_item_t        res_q;

	// Derived values
	logic [OFF_W-1:0] gsize;
	logic             grow_fail;
	logic [OFF_W-1:0] rd_size;
	logic [OFF_W-1:0] nxt;
	logic [OFF_W-1:0] psize;
	logic [OFF_W-1:0] nsize;
	logic [OFF_W-1:0] req_ext;
	logic [OFF_W-1:0] chunk_ext;
	logic [OFF_W-1:0] addr_ext;
	logic [OFF_W-1:0] rem;

	assign rd        = oor_s1 ? 32'd0 : mem_q;
	assign rd_size   = tag_size(rd);
	assign nxt       = bp_q + size_q;
	assign psize     = tag_size(ptag_q);
	assign nsize     = rd_size;
	assign gsize     = grow_size(grow_bytes_q);
	assign grow_fail = (gsize == '0) || (break_q > HEAP_END) || (gsize > HEAP_END - break_q);
	assign req_ext   = OFF_W'(in_item.request_size);
	assign chunk_ext = OFF_W'(chunk_q);
	assign addr_ext  = OFF_W'(addr_q);
	assign rem       = size_q - asize_q;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Memory port: one access per cycle, chosen by the sequencer state
	always_comb begin
		mem_we    = 1'b0;
		mem_off   = bp_q - OFF_W'(4);
		mem_wdata = 32'd0;
		unique case (state_q)
			S_INIT_W: begin
				mem_we = 1'b1;
				unique case (cnt_q)
					2'd0: begin mem_off = OFF_W'(0);  mem_wdata = 32'd0; end
					2'd1: begin mem_off = OFF_W'(4);  mem_wdata = make_tag(OFF_W'(8), 1'b1); end
					2'd2: begin mem_off = OFF_W'(8);  mem_wdata = make_tag(OFF_W'(8), 1'b1); end
					default: begin mem_off = OFF_W'(12); mem_wdata = make_tag('0, 1'b1); end
				endcase
			end
			S_GROW_W: begin
				mem_we = 1'b1;
				unique case (cnt_q)
					2'd0: begin mem_off = bp_q - OFF_W'(4); mem_wdata = make_tag(size_q, 1'b0); end
					2'd1: begin mem_off = nxt - OFF_W'(8);  mem_wdata = make_tag(size_q, 1'b0); end
					default: begin mem_off = nxt - OFF_W'(4); mem_wdata = make_tag('0, 1'b1); end
				endcase
			end
			S_MRG_RP: mem_off = bp_q - OFF_W'(8);
			S_MRG_RN: mem_off = nxt - OFF_W'(4);
			S_MRG_W, S_FREE_W: begin
				mem_we    = 1'b1;
				mem_wdata = make_tag(size_q, 1'b0);
				mem_off   = (cnt_q == 2'd0) ? bp_q - OFF_W'(4) : nxt - OFF_W'(8);
			end
			S_CARVE_W: begin
				mem_we = 1'b1;
				unique case (cnt_q)
					2'd0: begin
						mem_off   = bp_q - OFF_W'(4);
						mem_wdata = make_tag(split_q ? asize_q : size_q, 1'b1);
					end
					2'd1: begin
						mem_off   = (split_q ? bp_q + asize_q : nxt) - OFF_W'(8);
						mem_wdata = make_tag(split_q ? asize_q : size_q, 1'b1);
					end
					2'd2: begin mem_off = bp_q + asize_q - OFF_W'(4); mem_wdata = make_tag(rem, 1'b0); end
					default: begin mem_off = nxt - OFF_W'(8); mem_wdata = make_tag(rem, 1'b0); end
				endcase
			end
			S_SC_RN: mem_off = nxt - OFF_W'(4);
			default: mem_off = bp_q - OFF_W'(4);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we && mem_off[OFF_W-1:OFF_W-2] == 2'b00)
			heap_mem[mem_off[IDX_W+1:2]] <= mem_wdata;
		mem_q  <= heap_mem[mem_off[IDX_W+1:2]];
		oor_s1 <= (mem_off[OFF_W-1:OFF_W-2] != 2'b00);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			break_q      <= '0;
			rover_q      <= '0;
			ready_q      <= 1'b0;
			chunk_q      <= CHUNK_RESET;
			out_valid    <= 1'b0;
			cnt_q        <= '0;
			loop2_q      <= 1'b0;
			split_q      <= 1'b0;
			out_item     <= '0;
			res_q        <= '0;
			op_q         <= '0;
			addr_q       <= '0;
			asize_q      <= '0;
			bp_q         <= '0;
			size_q       <= '0;
			grow_bytes_q <= '0;
			ptag_q       <= '0;
		end else begin
			if (cfg_valid) begin
				priority if (cfg_data < CHUNK_MIN)      chunk_q <= CHUNK_MIN;
				else if (cfg_data > CHUNK_MAX)          chunk_q <= CHUNK_MAX;
				else                                    chunk_q <= cfg_data;
			end
			// the done state reloads the output itself
			if (out_valid && out_ready && state_q != S_DONE)
				out_valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q   <= in_item.opcode;
						addr_q <= in_item.block_address;
						cnt_q  <= '0;
						unique case (in_item.opcode)
							OP_INIT: begin
								ready_q <= 1'b0;
								state_q <= S_INIT_W;
							end
							OP_ALLOC: begin
								priority if (!ready_q) begin
									res_q.status <= ST_NOT_INIT;
									state_q      <= S_DONE;
								end else if (in_item.request_size == '0) begin
									res_q.status <= ST_ZERO;
									state_q      <= S_DONE;
								end else begin
									asize_q <= (in_item.request_size <= 17'd8) ? MIN_BLOCK :
										((req_ext + OFF_W'(15)) & ~OFF_W'(7));
									bp_q    <= rover_q;
									loop2_q <= 1'b0;
									state_q <= S_SC_H;
								end
							end
							OP_FREE: begin
								if (!ready_q) begin
									res_q.status <= ST_NOT_INIT;
									state_q      <= S_DONE;
								end else begin
									bp_q    <= OFF_W'(8);
									state_q <= S_FR_H;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_INIT_W: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						break_q      <= OFF_W'(16);
						rover_q      <= OFF_W'(8);
						grow_bytes_q <= chunk_ext;
						state_q      <= S_GROW;
					end
				end
				S_GROW: begin
					if (grow_fail) begin
						res_q.status <= ST_NO_MEM;
						state_q      <= S_DONE;
					end else begin
						bp_q    <= break_q;
						size_q  <= gsize;
						break_q <= break_q + gsize;
						cnt_q   <= '0;
						state_q <= S_GROW_W;
					end
				end
				S_GROW_W: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd2)
						state_q <= S_MRG_RP;
				end
				S_MRG_RP: state_q <= S_MRG_RN;
				S_MRG_RN: begin
					ptag_q  <= rd;
					state_q <= S_MRG_EV;
				end
				S_MRG_EV: begin
					// four coalescing cases from the neighbor tags
					size_q <= size_q + (rd[0] ? '0 : nsize) + (ptag_q[0] ? '0 : psize);
					if (!ptag_q[0])
						bp_q <= bp_q - psize;
					cnt_q   <= '0;
					state_q <= (ptag_q[0] && rd[0]) ? S_MRG_END : S_MRG_W;
				end
				S_MRG_W: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd1)
						state_q <= S_MRG_END;
				end
				S_MRG_END: begin
					rover_q <= bp_q;
					unique case (op_q)
						OP_INIT: begin
							ready_q <= 1'b1;
							state_q <= S_DONE;
						end
						OP_ALLOC: state_q <= S_CARVE;
						default:  state_q <= S_DONE;
					endcase
				end
				S_CARVE: begin
					split_q <= (rem >= MIN_BLOCK);
					res_q   <= '{status: ST_OK, payload_address: bp_q[15:0],
						granted_bytes: (rem >= MIN_BLOCK) ? asize_q[16:0] : size_q[16:0]};
					rover_q <= bp_q;
					cnt_q   <= '0;
					state_q <= S_CARVE_W;
				end
				S_CARVE_W: begin
					cnt_q <= cnt_q + 2'd1;
					if ((!split_q && cnt_q == 2'd1) || cnt_q == 2'd3)
						state_q <= S_DONE;
				end
				S_SC_H: state_q <= S_SC_HD;
				S_SC_HD: begin
					size_q <= rd_size;
					if (loop2_q && (bp_q == rover_q || (rd_size == '0 && bp_q != OFF_W'(8)))) begin
						grow_bytes_q <= (asize_q > chunk_ext) ? asize_q : chunk_ext;
						state_q      <= S_GROW;
					end else begin
						state_q <= S_SC_RN;
					end
				end
				S_SC_RN: state_q <= S_SC_EV;
				S_SC_EV: begin
					priority if (!loop2_q && rd_size == '0) begin
						// end of heap: wrap to the start
						loop2_q <= 1'b1;
						bp_q    <= OFF_W'(8);
						state_q <= S_SC_H;
					end else begin
						bp_q   <= nxt;
						size_q <= rd_size;
						priority if (!rd[0] && rd_size >= asize_q) begin
							state_q <= S_CARVE;
						end else if (loop2_q &&
							(nxt == rover_q || (rd_size == '0 && nxt != OFF_W'(8)))) begin
							grow_bytes_q <= (asize_q > chunk_ext) ? asize_q : chunk_ext;
							state_q      <= S_GROW;
						end else begin
							state_q <= S_SC_RN;
						end
					end
				end
				S_FR_H: state_q <= S_FR_HD;
				S_FR_HD: begin
					bp_q    <= OFF_W'(8) + rd_size;
					state_q <= S_FR_R;
				end
				S_FR_R: state_q <= S_FR_EV;
				S_FR_EV: begin
					priority if (rd_size == '0) begin
						state_q <= S_DONE;
					end else if (bp_q == addr_ext) begin
						size_q  <= rd_size;
						cnt_q   <= '0;
						state_q <= rd[0] ? S_FREE_W : S_DONE;
					end else if (bp_q > addr_ext) begin
						state_q <= S_DONE;
					end else begin
						bp_q    <= bp_q + rd_size;
						state_q <= S_FR_R;
					end
				end
				S_FREE_W: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd1)
						state_q <= S_MRG_RP;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_item  <= res_q;
						res_q     <= '0;
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Checks
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !mem_we)
		else $error("heap write outside a command");

	a_break_bound: assert property (@(posedge clk) disable iff (!arst_n)
		break_q <= HEAP_END)
		else $error("break past heap end");

	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		(break_q[2:0] == 3'd0) && (rover_q[2:0] == 3'd0))
		else $error("break or rover misaligned");

	a_ready_init: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> $past(op_q) == OP_INIT)
		else $error("heap ready set outside initialize");

	a_chunk_range: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_q >= CHUNK_MIN && chunk_q <= CHUNK_MAX)
		else $error("chunk size out of range");

endmodule
